// ===== hw/rtl/sh1_pkg.sv =====
// shared types and constants for the byte-stream sha-1 hasher
// no dependencies; used by every module of the block
package sh1_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_t;

  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LAST_POS    = 6'h3f;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [2:0] LAST_INDEX  = 3'd4;

endpackage

// ===== hw/rtl/sha1_stream_hasher_core.sv =====
// sha-1 over a byte stream: message bytes are absorbed in the idle state, and every 64th byte
// starts the 80 one-per-cycle rounds followed by the chaining add
// finish: byte-serial padding, the rounds and chaining add, a second padding and compression
// when the fill was 56 bytes or more, then 5 digest beats, one per cycle unless the receiver stalls
// a 4-beat input queue keeps taking bytes while the engine compresses, until the queue is full
// reset: synchronous; queue empties, chaining values return to initial, count to zero
module sha1_stream_hasher_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sh1_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sh1_pkg::result_t result
);

  logic           q_valid;
  logic           q_pop;
  sh1_pkg::item_t q_item;

  sh1_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  sh1_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// ===== hw/rtl/sh1_front.sv =====
// front part: accepts input beats and queues them for the hash engine
// depends on sh1_pkg
module sh1_front #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  sh1_pkg::item_t item,
  output logic          q_valid,
  output sh1_pkg::item_t q_item,
  input  logic          q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  sh1_pkg::item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign item_stall = (count == CNT_FULL);
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];
  assign push       = item_valid && !item_stall;
  assign pop        = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

endmodule

// ===== hw/rtl/sh1_engine.sv =====
// back part: byte packing, padding, 80-round compression and digest output
// depends on sh1_pkg
module sh1_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sh1_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output sh1_pkg::result_t result
);

  sh1_pkg::state_t state;
  sh1_pkg::state_t state_next;

  logic [31:0] h [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [63:0] byte_total;
  logic [5:0]  pcnt;
  logic [6:0]  rnd;
  logic [2:0]  idx;
  logic        len_blk;
  logic        fin_mode;

  logic [5:0]  pos;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        emit_load;
  logic [63:0] bit_len;
  logic [63:0] len_shifted;
  logic [31:0] wr;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  assign pos         = byte_total[5:0];
  assign bit_len     = {byte_total[60:0], 3'b000};
  assign len_shifted = bit_len >> {~pcnt[2:0], 3'b000};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sh1_pkg::S_IDLE: begin
        if (q_valid) begin
          if (pos == sh1_pkg::LAST_POS) begin
            state_next = sh1_pkg::S_ROUND;
          end else if (q_item.kind == sh1_pkg::KIND_FINISH) begin
            state_next = sh1_pkg::S_PAD;
          end
        end
      end
      sh1_pkg::S_PAD: begin
        if (pcnt == sh1_pkg::LAST_POS) begin
          state_next = sh1_pkg::S_ROUND;
        end
      end
      sh1_pkg::S_ROUND: begin
        if (rnd == sh1_pkg::LAST_ROUND) begin
          state_next = sh1_pkg::S_FINAL;
        end
      end
      sh1_pkg::S_FINAL: begin
        if (!fin_mode) begin
          state_next = sh1_pkg::S_IDLE;
        end else if (len_blk) begin
          state_next = sh1_pkg::S_EMIT;
        end else begin
          state_next = sh1_pkg::S_PAD;
        end
      end
      sh1_pkg::S_EMIT: begin
        if (emit_load && idx == sh1_pkg::LAST_INDEX) begin
          state_next = sh1_pkg::S_IDLE;
        end
      end
      default: state_next = sh1_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    shift_en   = 1'b0;
    shift_byte = '0;
    emit_load  = 1'b0;
    case (state)
      sh1_pkg::S_IDLE: begin
        q_pop      = q_valid;
        shift_en   = q_valid;
        shift_byte = (q_item.kind == sh1_pkg::KIND_FINISH) ? sh1_pkg::PAD_MARK
                                                           : q_item.data_byte;
      end
      sh1_pkg::S_PAD: begin
        shift_en = 1'b1;
        // length goes into the last eight bytes of the final block
        if (len_blk && pcnt[5:3] == 3'b111) begin
          shift_byte = len_shifted[7:0];
        end
      end
      sh1_pkg::S_EMIT: begin
        emit_load = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  // round logic
  always_comb begin
    if (rnd < 7'd16) begin
      wr = w[0];
    end else begin
      wr = w[13] ^ w[8] ^ w[2] ^ w[0];
      wr = {wr[30:0], wr[31]};
    end
    if (rnd < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = sh1_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = sh1_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = sh1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sh1_pkg::K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sh1_pkg::S_IDLE;
      result_valid <= 1'b0;
      byte_total   <= '0;
      fin_mode     <= 1'b0;
      len_blk      <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= sh1_pkg::H_INIT[i];
      end
    end else begin
      state <= state_next;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        sh1_pkg::S_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == sh1_pkg::KIND_FINISH) begin
              fin_mode <= 1'b1;
              len_blk  <= (pos[5:3] != 3'b111);
            end else begin
              byte_total <= byte_total + 64'd1;
            end
          end
        end
        sh1_pkg::S_FINAL: begin
          for (int i = 0; i < 5; i++) begin
            h[i] <= h[i] + ((i == 0) ? a : (i == 1) ? b : (i == 2) ? c :
                            (i == 3) ? d : e);
          end
          if (fin_mode && !len_blk) begin
            len_blk <= 1'b1;
          end
        end
        sh1_pkg::S_EMIT: begin
          if (emit_load) begin
            result_valid <= 1'b1;
            if (idx == sh1_pkg::LAST_INDEX) begin
              byte_total <= '0;
              fin_mode   <= 1'b0;
              for (int i = 0; i < 5; i++) begin
                h[i] <= sh1_pkg::H_INIT[i];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], shift_byte};
    end
    case (state)
      sh1_pkg::S_IDLE: begin
        if (q_valid && q_item.kind == sh1_pkg::KIND_FINISH) begin
          pcnt <= pos + 6'd1;
        end
      end
      sh1_pkg::S_PAD: begin
        pcnt <= pcnt + 6'd1;
      end
      sh1_pkg::S_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= wr;
        a   <= t;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        rnd <= rnd + 7'd1;
      end
      sh1_pkg::S_FINAL: begin
        pcnt <= '0;
        idx  <= '0;
      end
      sh1_pkg::S_EMIT: begin
        if (emit_load) begin
          result.digest_word <= h[idx];
          result.word_index  <= idx;
          result.last_word   <= (idx == sh1_pkg::LAST_INDEX);
          idx                <= idx + 3'd1;
        end
      end
      default: begin
      end
    endcase
    if (state_next == sh1_pkg::S_ROUND && state != sh1_pkg::S_ROUND) begin
      a   <= h[0];
      b   <= h[1];
      c   <= h[2];
      d   <= h[3];
      e   <= h[4];
      rnd <= '0;
    end
  end

endmodule

// ===== hw/rtl/sh1_checker.sv =====
// port-level checks on the hasher output sequence
// depends on sh1_pkg; bound to sha1_stream_hasher_core
module sh1_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input sh1_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.word_index <= sh1_pkg::LAST_INDEX)
    else $error("word index out of range");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_word == (result.word_index == sh1_pkg::LAST_INDEX)))
    else $error("last flag does not match word index");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_word |=>
      !result_valid || result.word_index == $past(result.word_index) + 3'd1)
    else $error("digest words out of order");

endmodule

bind sha1_stream_hasher_core sh1_checker u_sh1_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// ===== tb/tb_top.sv =====
// self-checking bench for sha1_stream_hasher_core: byte stream in, digest words out
// depends on sh1_pkg and the core; a class keeps the running sha-1 state and queued digests
class sha1_digest_board;
  logic [31:0] chain [5];
  logic [31:0] blk [16];
  logic [63:0] nbytes;
  sh1_pkg::result_t pending [$];
  int errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 5; i++) chain[i] = sh1_pkg::H_INIT[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    nbytes = '0;
  endfunction

  function logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wr;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) wr = w[r];
      else begin
        wr = rol(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d)); k = sh1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = sh1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c)); k = sh1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sh1_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + wr;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function void put_byte(int pos, logic [7:0] v);
    blk[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
  endfunction

  function void note_item(sh1_pkg::item_t it);
    int pos;
    logic [63:0] bits;
    sh1_pkg::result_t r;
    pos = int'(nbytes[5:0]);
    if (it.kind == sh1_pkg::KIND_ABSORB) begin
      put_byte(pos, it.data_byte);
      nbytes += 1;
      if (pos == 63) compress();
    end else begin
      bits = nbytes << 3;
      put_byte(pos, sh1_pkg::PAD_MARK);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 5; i++) begin
        r.digest_word = chain[i];
        r.word_index = 3'(i);
        r.last_word = (i == 4);
        pending.push_back(r);
      end
      restart();
    end
  endfunction

  function void check_word(sh1_pkg::result_t got);
    sh1_pkg::result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected digest beat %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.digest_word !== want.digest_word) begin
      $display("%0t: digest_word expected %h got %h", $time, want.digest_word,
               got.digest_word);
      errors++;
    end
    if (got.word_index !== want.word_index) begin
      $display("%0t: word_index expected %0d got %0d", $time, want.word_index,
               got.word_index);
      errors++;
    end
    if (got.last_word !== want.last_word) begin
      $display("%0t: last_word expected %b got %b", $time, want.last_word,
               got.last_word);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  sh1_pkg::item_t item;
  sh1_pkg::result_t result;

  sha1_digest_board board;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  longint cycles;

  sha1_stream_hasher_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) board.check_word(result);
      result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[sha1_stream_hasher_core] ERROR");
      $finish;
    end
  end

  // valid stays up between back-to-back beats and drops only while idling
  task automatic send_beat(logic k, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{kind: k, data_byte: b};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item('{kind: k, data_byte: b});
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      send_beat(sh1_pkg::KIND_ABSORB, 8'($urandom_range(255)));
    end
    send_beat(sh1_pkg::KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    cycles = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, byte extremes, a full block then a finish at the last slot
    send_beat(sh1_pkg::KIND_FINISH, 8'hff);
    send_beat(sh1_pkg::KIND_ABSORB, 8'h00);
    send_beat(sh1_pkg::KIND_ABSORB, 8'hff);
    send_beat(sh1_pkg::KIND_FINISH, 8'h00);
    send_message(127);
    drain();

    // long receiver hold-off: the first digest blocks the engine and the input backs up
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(1);
        send_message(6);
      end
    join
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 33 : 0;
      for (int m = 0; m < 4; m++) begin
        send_message($urandom_range(0, 3));
        if (m == 1) drain();
      end
    end
    drain();
    repeat (200) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("[sha1_stream_hasher_core] OK");
    else
      $display("[sha1_stream_hasher_core] ERROR");
    $finish;
  end
endmodule
